// File: rtl/ije_pkg.sv
// Shared types and codes for the interval join engine.
// No dependencies; imported by ije_ram users and the top level.
`default_nettype none

package ije_pkg;

    localparam int KIND_BITS        = 2;
    localparam int MODE_BITS        = 3;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int RIGHT_INDEX_BITS = 6;

    localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_PROBE  = 2'd2;

    localparam logic [MODE_BITS-1:0] MODE_BEFORE     = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_AFTER      = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_OVERLAPS   = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_DURING     = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_PRECEDES   = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_IMMEDIATE  = 3'd5;
    localparam logic [MODE_BITS-1:0] MODE_FOLLOWED   = 3'd6;
    localparam logic [MODE_BITS-1:0] MODE_UNTIL      = 3'd7;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE         = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WITHIN_EN    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WITHIN_LIMIT = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

`default_nettype wire

// File: rtl/ije_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ije_ram #(
    parameter int WIDTH = 112,
    parameter int DEPTH = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/interval_join_engine_core.sv
// Interval join engine top level: right-event table, probe scan sequencer, result register.
// Depends on ije_pkg and ije_ram.
//
// Clear and append words complete without a scan; appends past TABLE_DEPTH entries are dropped
// and raise the sticky overflow flag. A probe word scans the table in load order, one entry
// per cycle through the table RAM's read port and a single compare unit, unless the result
// side stalls. In modes before through immediately-followed every matching entry yields a
// result word, the last one flagged; followed-by and until yield only the earliest-starting
// entry at or after the probe's end. A probe with no match yields one word with found low.
// The input side is not ready while a probe scan runs. Configuration writes are taken in any
// cycle.
`default_nettype none

module interval_join_engine_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int TIME_BITS   = 48,
    parameter int TAG_BITS    = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,

    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [ije_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  wire logic [TIME_BITS-1:0]                    cfg_data,

    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic [ije_pkg::KIND_BITS-1:0]           kind,
    input  wire logic [TIME_BITS-1:0]                    ev_start,
    input  wire logic [TIME_BITS-1:0]                    ev_end,
    input  wire logic [TAG_BITS-1:0]                     event_type,

    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output logic                                         found,
    output logic      [TIME_BITS-1:0]                    out_start,
    output logic      [TIME_BITS-1:0]                    out_end,
    output logic      [TAG_BITS-1:0]                     left_tag,
    output logic      [TAG_BITS-1:0]                     right_tag,
    output logic      [TIME_BITS-1:0]                    gap,
    output logic      [ije_pkg::RIGHT_INDEX_BITS-1:0]    right_index,
    output logic                                         last,
    output logic                                         overflow
);

    import ije_pkg::*;

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = 2 * TIME_BITS + TAG_BITS;

    state_t state_reg, state_next;

    logic [MODE_BITS-1:0] mode_reg;
    logic                 within_en_reg;
    logic [TIME_BITS-1:0] within_limit_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic [CNT_W-1:0] idx_reg, idx_next;

    logic [TIME_BITS-1:0] ls_reg, ls_next;
    logic [TIME_BITS-1:0] le_reg, le_next;
    logic [TAG_BITS-1:0]  lt_reg, lt_next;
    logic [TIME_BITS:0]   le_lim_reg, le_lim_next;

    logic                        pend_valid_reg, pend_valid_next;
    logic [TIME_BITS-1:0]        pend_rs_reg, pend_rs_next;
    logic [TIME_BITS-1:0]        pend_start_reg, pend_start_next;
    logic [TIME_BITS-1:0]        pend_end_reg, pend_end_next;
    logic [TAG_BITS-1:0]         pend_tag_reg, pend_tag_next;
    logic [TIME_BITS-1:0]        pend_gap_reg, pend_gap_next;
    logic [RIGHT_INDEX_BITS-1:0] pend_idx_reg, pend_idx_next;

    logic                        out_valid_reg, out_valid_next;
    logic                        found_reg, found_next;
    logic [TIME_BITS-1:0]        out_start_reg, out_start_next;
    logic [TIME_BITS-1:0]        out_end_reg, out_end_next;
    logic [TAG_BITS-1:0]         left_tag_reg, left_tag_next;
    logic [TAG_BITS-1:0]         right_tag_reg, right_tag_next;
    logic [TIME_BITS-1:0]        gap_reg, gap_next;
    logic [RIGHT_INDEX_BITS-1:0] right_index_reg, right_index_next;
    logic                        last_reg, last_next;
    logic                        overflow_reg, overflow_next;

    logic               wr_en;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] rd_data;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;

    logic [TIME_BITS-1:0] rs;
    logic [TIME_BITS-1:0] re;
    logic [TAG_BITS-1:0]  rt;

    logic                        rel_hit;
    logic                        cand;
    logic                        better;
    logic                        out_free;
    logic [TIME_BITS-1:0]        cur_start;
    logic [TIME_BITS-1:0]        cur_end;
    logic [TIME_BITS-1:0]        cur_gap;
    logic [RIGHT_INDEX_BITS-1:0] cur_idx;

    ije_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign wr_data = {event_type, ev_end, ev_start};
    assign wr_addr = count_reg[IDX_W-1:0];
    assign rd_addr = idx_next[IDX_W-1:0];

    assign rs = rd_data[TIME_BITS-1:0];
    assign re = rd_data[2*TIME_BITS-1:TIME_BITS];
    assign rt = rd_data[ENTRY_W-1:2*TIME_BITS];

    always_comb
    begin
        case (mode_reg)
            MODE_BEFORE:    rel_hit = le_reg <= rs;
            MODE_AFTER:     rel_hit = ls_reg >= re;
            MODE_OVERLAPS:  rel_hit = (ls_reg <= re) && (rs <= le_reg);
            MODE_DURING:    rel_hit = (rs <= ls_reg) && (le_reg <= re);
            MODE_PRECEDES:  rel_hit = le_reg < rs;
            MODE_IMMEDIATE: rel_hit = le_reg == rs;
            default:        rel_hit = 1'b0;
        endcase
    end

    assign cand = (le_reg <= rs)
                  && !((mode_reg == MODE_FOLLOWED) && within_en_reg
                       && ({1'b0, rs} > le_lim_reg));
    assign better    = !pend_valid_reg || (rs < pend_rs_reg);
    assign cur_start = (ls_reg < rs) ? ls_reg : rs;
    assign cur_end   = (le_reg > re) ? le_reg : re;
    assign cur_gap   = (rs > le_reg) ? (rs - le_reg) : '0;
    assign cur_idx   = RIGHT_INDEX_BITS'(idx_reg[IDX_W-1:0]);
    assign out_free  = !out_valid_reg || out_ready;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_BEFORE;
            within_en_reg    <= 1'b0;
            within_limit_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODE:         mode_reg         <= cfg_data[MODE_BITS-1:0];
                CFG_WITHIN_EN:    within_en_reg    <= cfg_data[0];
                CFG_WITHIN_LIMIT: within_limit_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            dropped_reg    <= 1'b0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            dropped_reg    <= dropped_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ls_reg          <= ls_next;
        le_reg          <= le_next;
        lt_reg          <= lt_next;
        le_lim_reg      <= le_lim_next;
        pend_rs_reg     <= pend_rs_next;
        pend_start_reg  <= pend_start_next;
        pend_end_reg    <= pend_end_next;
        pend_tag_reg    <= pend_tag_next;
        pend_gap_reg    <= pend_gap_next;
        pend_idx_reg    <= pend_idx_next;
        found_reg       <= found_next;
        out_start_reg   <= out_start_next;
        out_end_reg     <= out_end_next;
        left_tag_reg    <= left_tag_next;
        right_tag_reg   <= right_tag_next;
        gap_reg         <= gap_next;
        right_index_reg <= right_index_next;
        last_reg        <= last_next;
        overflow_reg    <= overflow_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        dropped_next     = dropped_reg;
        idx_next         = idx_reg;
        ls_next          = ls_reg;
        le_next          = le_reg;
        lt_next          = lt_reg;
        le_lim_next      = le_lim_reg;
        pend_valid_next  = pend_valid_reg;
        pend_rs_next     = pend_rs_reg;
        pend_start_next  = pend_start_reg;
        pend_end_next    = pend_end_reg;
        pend_tag_next    = pend_tag_reg;
        pend_gap_next    = pend_gap_reg;
        pend_idx_next    = pend_idx_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        found_next       = found_reg;
        out_start_next   = out_start_reg;
        out_end_next     = out_end_reg;
        left_tag_next    = left_tag_reg;
        right_tag_next   = right_tag_reg;
        gap_next         = gap_reg;
        right_index_next = right_index_reg;
        last_next        = last_reg;
        overflow_next    = overflow_reg;
        wr_en            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (in_valid)
                begin
                    case (kind)
                        KIND_CLEAR:
                        begin
                            count_next   = '0;
                            dropped_next = 1'b0;
                        end
                        KIND_APPEND:
                        begin
                            if (count_reg < CNT_W'(TABLE_DEPTH))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        KIND_PROBE:
                        begin
                            ls_next         = ev_start;
                            le_next         = ev_end;
                            lt_next         = event_type;
                            le_lim_next     = {1'b0, ev_end} + {1'b0, within_limit_reg};
                            pend_valid_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (idx_reg == count_reg)
                begin
                    // finish: flush the held match, or report no match
                    if (out_free)
                    begin
                        out_valid_next   = 1'b1;
                        found_next       = pend_valid_reg;
                        left_tag_next    = lt_reg;
                        last_next        = 1'b1;
                        overflow_next    = dropped_reg;
                        if (pend_valid_reg)
                        begin
                            out_start_next   = pend_start_reg;
                            out_end_next     = pend_end_reg;
                            right_tag_next   = pend_tag_reg;
                            gap_next         = pend_gap_reg;
                            right_index_next = pend_idx_reg;
                        end
                        else
                        begin
                            out_start_next   = ls_reg;
                            out_end_next     = le_reg;
                            right_tag_next   = '0;
                            gap_next         = '0;
                            right_index_next = '0;
                        end
                        pend_valid_next = 1'b0;
                        idx_next        = '0;
                        state_next      = ST_IDLE;
                    end
                end
                else if (mode_reg inside {MODE_FOLLOWED, MODE_UNTIL})
                begin
                    if (cand && better)
                    begin
                        pend_valid_next = 1'b1;
                        pend_rs_next    = rs;
                        pend_start_next = cur_start;
                        pend_end_next   = cur_end;
                        pend_tag_next   = rt;
                        pend_gap_next   = cur_gap;
                        pend_idx_next   = cur_idx;
                    end
                    idx_next = idx_reg + CNT_W'(1);
                end
                else if (!(rel_hit && pend_valid_reg && !out_free))
                begin
                    if (rel_hit)
                    begin
                        // hold the newest match, push the previous one out
                        if (pend_valid_reg)
                        begin
                            out_valid_next   = 1'b1;
                            found_next       = 1'b1;
                            out_start_next   = pend_start_reg;
                            out_end_next     = pend_end_reg;
                            left_tag_next    = lt_reg;
                            right_tag_next   = pend_tag_reg;
                            gap_next         = pend_gap_reg;
                            right_index_next = pend_idx_reg;
                            last_next        = 1'b0;
                            overflow_next    = dropped_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_rs_next    = rs;
                        pend_start_next = cur_start;
                        pend_end_next   = cur_end;
                        pend_tag_next   = rt;
                        pend_gap_next   = cur_gap;
                        pend_idx_next   = cur_idx;
                    end
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
                idx_next   = '0;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign out_start   = out_start_reg;
    assign out_end     = out_end_reg;
    assign left_tag    = left_tag_reg;
    assign right_tag   = right_tag_reg;
    assign gap         = gap_reg;
    assign right_index = right_index_reg;
    assign last        = last_reg;
    assign overflow    = overflow_reg;

endmodule

`default_nettype wire
